// ===== sv/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal unit.
// No dependencies; used by every module of the block.
package vrt_pkg;

  // Default configuration
  localparam int GRID_SIZE_DEF     = 32;
  localparam int MATERIAL_BITS_DEF = 8;

  // Datapath widths
  localparam int NUM_W   = 60;  // divider dividend / sqrt radicand
  localparam int DEN_W   = 31;  // divider divisor
  localparam int ROOT_W  = 30;  // square root result
  localparam int TIME_W  = 57;  // traversal times, units of 2^-24
  localparam int CELL_W  = 14;  // signed cell coordinate
  localparam int DABS_W  = 31;  // normalized direction magnitude, Q1.30
  localparam int COORD_W = 24;  // Q12.12 coordinates
  localparam int DIR_W   = 16;  // Q2.14 direction

  localparam logic [TIME_W-1:0] TIME_INF = '1;

  // Face axis codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RAY   = 1'b1;

  // Setup division being run for one axis
  typedef enum logic [1:0] {
    OP_DABS,
    OP_TNEXT,
    OP_TDELTA
  } div_op_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WALK_RD,
    S_WALK_CHK,
    S_PNT,
    S_DONE
  } state_t;

  // Handshake between sequencer and an iterative arithmetic unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic running;
  } unit_rsp_t;

endpackage

// ===== sv/voxel_ray_traversal_unit.sv =====
// Voxel ray traversal unit: voxel writes and 3D DDA ray queries.
// Write: accepted while idle, no result. Ray: sum of squares, square root, up to 9 divisions
// (dabs, tnext, tdelta per axis; a division is skipped where the axis does not move), DDA steps
// (a step inside the volume reads the voxel memory, then checks it), hit point, result strobe.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
// Reset: after rst the memory is swept to air, GRID_SIZE^3 cycles with busy high.
module voxel_ray_traversal_unit #(
  parameter int GRID_SIZE     = vrt_pkg::GRID_SIZE_DEF,
  parameter int MATERIAL_BITS = vrt_pkg::MATERIAL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [4:0]          voxel_x,
  input  logic [4:0]          voxel_y,
  input  logic [4:0]          voxel_z,
  input  logic [7:0]          material_in,
  input  logic signed [23:0]  origin_x,
  input  logic signed [23:0]  origin_y,
  input  logic signed [23:0]  origin_z,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic [23:0]         max_distance,
  output logic                done,
  output logic                hit,
  output logic [4:0]          hit_x,
  output logic [4:0]          hit_y,
  output logic [4:0]          hit_z,
  output logic [7:0]          hit_material,
  output logic [23:0]         hit_distance,
  output logic [1:0]          normal_axis,
  output logic                normal_negative,
  output logic signed [23:0]  point_x,
  output logic signed [23:0]  point_y,
  output logic signed [23:0]  point_z
);

  localparam int AW   = $clog2(GRID_SIZE * GRID_SIZE * GRID_SIZE);
  localparam int GW   = $clog2(GRID_SIZE);
  localparam int NW   = vrt_pkg::NUM_W;
  localparam int TW   = vrt_pkg::TIME_W;
  localparam int CLW  = vrt_pkg::CELL_W;
  localparam int DAW  = vrt_pkg::DABS_W;
  localparam int OW   = vrt_pkg::COORD_W;
  localparam int DRW  = vrt_pkg::DIR_W;
  localparam int RW   = vrt_pkg::ROOT_W;
  localparam int PW   = OW + 3;

  vrt_pkg::state_t state, state_next;

  // Latched request
  logic signed [OW-1:0]  org   [3];
  logic signed [DRW-1:0] dir_r [3];
  logic [35:0]           limit;

  // Setup and walk registers
  logic [31:0]           sq;
  logic [RW-1:0]         len;
  logic [1:0]            ax;
  vrt_pkg::div_op_t      op;
  logic [DAW-1:0]        dabs   [3];
  logic [TW-1:0]         tnext  [3];
  logic [TW-1:0]         tdelta [3];
  logic signed [CLW-1:0] cur_cell [3];
  logic [2:0]            pos;
  logic [2:0]            moving;
  logic [TW-1:0]         travel;
  logic [1:0]            axis_r;
  logic                  neg_r;
  logic                  res_hit;
  logic [MATERIAL_BITS-1:0] res_mat;
  logic [1:0]            pidx;
  logic                  pphase;
  logic [54:0]           pprod;
  logic signed [OW-1:0]  pnt [3];

  // Control strobes
  logic mem_re;
  logic do_step;
  vrt_pkg::unit_req_t div_req, sqrt_req;
  vrt_pkg::unit_rsp_t div_rsp, sqrt_rsp;

  logic                  clearing;
  logic                  accept;
  logic                  mem_we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [MATERIAL_BITS-1:0] rdata;
  logic [NW-1:0]         div_num;
  logic [vrt_pkg::DEN_W-1:0] div_den;
  logic [NW-1:0]         div_q;
  logic [RW-1:0]         root;
  logic                  div_skip;

  assign accept = start && !busy;
  assign busy   = clearing || (state != vrt_pkg::S_IDLE);

  // Voxel write, ignored outside the volume
  assign mem_we = accept && (req_type == vrt_pkg::REQ_WRITE) &&
                  (9'(voxel_x) < 9'(GRID_SIZE)) && (9'(voxel_y) < 9'(GRID_SIZE)) &&
                  (9'(voxel_z) < 9'(GRID_SIZE));
  assign waddr  = AW'((AW'(voxel_x) * AW'(GRID_SIZE) + AW'(voxel_y)) * AW'(GRID_SIZE)
                      + AW'(voxel_z));
  assign raddr  = AW'((AW'(cur_cell[0][GW-1:0]) * AW'(GRID_SIZE)
                      + AW'(cur_cell[1][GW-1:0])) * AW'(GRID_SIZE)
                      + AW'(cur_cell[2][GW-1:0]));

  vrt_voxel_mem #(
    .GRID_SIZE     (GRID_SIZE),
    .MATERIAL_BITS (MATERIAL_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .we       (mem_we),
    .waddr    (waddr),
    .wdata    (MATERIAL_BITS'(material_in)),
    .re       (mem_re),
    .raddr    (raddr),
    .rdata    (rdata),
    .clearing (clearing)
  );

  // Sum of squares, one component per cycle
  logic signed [31:0] sq_prod;
  logic [31:0]        sq_sum;
  assign sq_prod = dir_r[ax] * dir_r[ax];
  assign sq_sum  = sq + 32'(unsigned'(sq_prod));

  vrt_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sqrt_req),
    .rad  ({sq, 28'd0}),
    .rsp  (sqrt_rsp),
    .root (root)
  );

  // Division operands per axis
  logic [DRW-1:0] mag;
  logic [12:0]    bnum;
  logic [11:0]    frac;
  assign mag  = dir_r[ax][DRW-1] ? DRW'(-dir_r[ax]) : DRW'(dir_r[ax]);
  assign frac = org[ax][11:0];
  assign bnum = pos[ax] ? (13'd4096 - 13'(frac)) : 13'(frac);

  always_comb begin
    div_num  = '0;
    div_den  = dabs[ax];
    div_skip = 1'b0;
    case (op)
      vrt_pkg::OP_DABS: begin
        div_num  = {mag, 44'd0};
        div_den  = vrt_pkg::DEN_W'(len);
        div_skip = (dir_r[ax] == '0);
      end
      vrt_pkg::OP_TNEXT: begin
        div_num  = NW'({bnum, 42'd0});
        div_skip = !moving[ax];
      end
      vrt_pkg::OP_TDELTA: begin
        div_num  = NW'(1) << 54;
        div_skip = !moving[ax];
      end
      default: begin
        div_skip = 1'b1;
      end
    endcase
  end

  vrt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .rsp  (div_rsp),
    .quot (div_q)
  );

  // Walk decisions
  logic       limit_hit;
  logic       in_grid;
  logic       exit_now;
  logic [1:0] step_ax;
  logic       last_div;
  logic       div_adv;

  assign limit_hit = travel >= TW'(limit);

  always_comb begin
    in_grid  = 1'b1;
    exit_now = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (cur_cell[i] < 0) begin
        in_grid = 1'b0;
        if (!(moving[i] && pos[i])) exit_now = 1'b1;
      end
      if (cur_cell[i] >= CLW'(GRID_SIZE)) begin
        in_grid = 1'b0;
        if (!(moving[i] && !pos[i])) exit_now = 1'b1;
      end
    end
  end

  // Ties go to z, then y
  always_comb begin
    if (tnext[0] < tnext[1] && tnext[0] < tnext[2]) step_ax = vrt_pkg::AXIS_X;
    else if (tnext[1] < tnext[2])                   step_ax = vrt_pkg::AXIS_Y;
    else                                            step_ax = vrt_pkg::AXIS_Z;
  end

  assign last_div = (ax == 2'd2) && (op == vrt_pkg::OP_TDELTA);
  assign div_adv  = ((state == vrt_pkg::S_DIV_GO) && div_skip) ||
                    ((state == vrt_pkg::S_DIV_WAIT) && div_rsp.done);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      vrt_pkg::S_IDLE: begin
        if (accept && req_type == vrt_pkg::REQ_RAY) state_next = vrt_pkg::S_SQ;
      end
      vrt_pkg::S_SQ: begin
        if (ax == 2'd2) state_next = (sq_sum == '0) ? vrt_pkg::S_DONE : vrt_pkg::S_SQRT_GO;
      end
      vrt_pkg::S_SQRT_GO: state_next = vrt_pkg::S_SQRT_WAIT;
      vrt_pkg::S_SQRT_WAIT: begin
        if (sqrt_rsp.done) state_next = vrt_pkg::S_DIV_GO;
      end
      vrt_pkg::S_DIV_GO: begin
        if (!div_skip)     state_next = vrt_pkg::S_DIV_WAIT;
        else if (last_div) state_next = vrt_pkg::S_WALK_RD;
      end
      vrt_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) state_next = last_div ? vrt_pkg::S_WALK_RD : vrt_pkg::S_DIV_GO;
      end
      vrt_pkg::S_WALK_RD: begin
        if (limit_hit)     state_next = vrt_pkg::S_DONE;
        else if (in_grid)  state_next = vrt_pkg::S_WALK_CHK;
        else if (exit_now) state_next = vrt_pkg::S_DONE;
      end
      vrt_pkg::S_WALK_CHK: begin
        state_next = (rdata != '0) ? vrt_pkg::S_PNT : vrt_pkg::S_WALK_RD;
      end
      vrt_pkg::S_PNT: begin
        if (pphase && pidx == 2'd2) state_next = vrt_pkg::S_DONE;
      end
      vrt_pkg::S_DONE: state_next = vrt_pkg::S_IDLE;
      default: state_next = vrt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mem_re         = 1'b0;
    do_step        = 1'b0;
    div_req.start  = 1'b0;
    sqrt_req.start = 1'b0;
    done           = 1'b0;
    case (state)
      vrt_pkg::S_SQRT_GO: sqrt_req.start = 1'b1;
      vrt_pkg::S_DIV_GO:  div_req.start  = !div_skip;
      vrt_pkg::S_WALK_RD: begin
        if (!limit_hit && in_grid)                mem_re  = 1'b1;
        else if (!limit_hit && !exit_now)         do_step = 1'b1;
      end
      vrt_pkg::S_WALK_CHK: do_step = (rdata == '0);
      vrt_pkg::S_DONE:     done    = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vrt_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  logic [23:0]           d12;
  logic [24:0]           off;
  logic signed [PW-1:0]  psum;
  assign d12  = travel[35:12];
  assign off  = pprod[54:30];
  assign psum = pos[pidx] ? PW'(org[pidx]) + PW'(off) : PW'(org[pidx]) - PW'(off);

  always_ff @(posedge clk) begin
    case (state)
      vrt_pkg::S_IDLE: begin
        if (accept) begin
          org[0]      <= origin_x;
          org[1]      <= origin_y;
          org[2]      <= origin_z;
          dir_r[0]    <= dir_x;
          dir_r[1]    <= dir_y;
          dir_r[2]    <= dir_z;
          limit       <= {max_distance, 12'd0};
          cur_cell[0] <= CLW'(origin_x >>> 12);
          cur_cell[1] <= CLW'(origin_y >>> 12);
          cur_cell[2] <= CLW'(origin_z >>> 12);
          pos         <= {!dir_z[DRW-1] && dir_z != '0, !dir_y[DRW-1] && dir_y != '0,
                          !dir_x[DRW-1] && dir_x != '0};
          sq          <= '0;
          ax          <= '0;
          travel      <= '0;
          axis_r      <= vrt_pkg::AXIS_NONE;
          neg_r       <= 1'b0;
          res_hit     <= 1'b0;
        end
      end
      vrt_pkg::S_SQ: begin
        sq <= sq_sum;
        ax <= ax + 1'b1;
      end
      vrt_pkg::S_SQRT_WAIT: begin
        if (sqrt_rsp.done) begin
          len <= root;
          ax  <= '0;
          op  <= vrt_pkg::OP_DABS;
        end
      end
      vrt_pkg::S_PNT: begin
        pphase <= !pphase;
        if (!pphase) begin
          pprod <= 55'(dabs[pidx]) * 55'(d12);
        end else begin
          pidx <= pidx + 1'b1;
          if (psum > PW'(8388607))       pnt[pidx] <= 24'sh7FFFFF;
          else if (psum < -PW'(8388608)) pnt[pidx] <= 24'sh800000;
          else                           pnt[pidx] <= OW'(psum);
        end
      end
      vrt_pkg::S_WALK_CHK: begin
        if (rdata != '0) begin
          res_hit <= 1'b1;
          res_mat <= rdata;
          pidx    <= '0;
          pphase  <= 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Setup division results
    if (div_adv) begin
      case (op)
        vrt_pkg::OP_DABS: begin
          dabs[ax]   <= div_skip ? '0 : div_q[DAW-1:0];
          moving[ax] <= !div_skip && (div_q[DAW-1:0] != '0);
        end
        vrt_pkg::OP_TNEXT:  tnext[ax]  <= div_skip ? vrt_pkg::TIME_INF : div_q[TW-1:0];
        vrt_pkg::OP_TDELTA: tdelta[ax] <= div_skip ? '0 : div_q[TW-1:0];
        default: begin
        end
      endcase
      case (op)
        vrt_pkg::OP_DABS:  op <= vrt_pkg::OP_TNEXT;
        vrt_pkg::OP_TNEXT: op <= vrt_pkg::OP_TDELTA;
        default: begin
          op <= vrt_pkg::OP_DABS;
          ax <= ax + 1'b1;
        end
      endcase
    end

    // One DDA step along the chosen axis
    if (do_step) begin
      travel            <= tnext[step_ax];
      tnext[step_ax]    <= tnext[step_ax] + tdelta[step_ax];
      cur_cell[step_ax] <= pos[step_ax] ? cur_cell[step_ax] + 1'b1
                                        : cur_cell[step_ax] - 1'b1;
      axis_r            <= step_ax;
      neg_r             <= pos[step_ax];
    end
  end

  // Result ports, zero on a miss (normal_axis reads AXIS_NONE)
  assign hit             = res_hit;
  assign hit_x           = res_hit ? 5'(cur_cell[0]) : '0;
  assign hit_y           = res_hit ? 5'(cur_cell[1]) : '0;
  assign hit_z           = res_hit ? 5'(cur_cell[2]) : '0;
  assign hit_material    = res_hit ? 8'(res_mat) : '0;
  assign hit_distance    = res_hit ? d12 : '0;
  assign normal_axis     = res_hit ? axis_r : vrt_pkg::AXIS_NONE;
  assign normal_negative = res_hit ? neg_r : 1'b0;
  assign point_x         = res_hit ? pnt[0] : '0;
  assign point_y         = res_hit ? pnt[1] : '0;
  assign point_z         = res_hit ? pnt[2] : '0;

  // Checks
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !clearing) else $error("voxel write during clearing sweep");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("unit still busy after result");

  a_ray_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == vrt_pkg::REQ_RAY |=> busy) else $error("ray not taken");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == vrt_pkg::REQ_WRITE |=> !done) else $error("write gave result");

  a_read_before_check: assert property (@(posedge clk) disable iff (rst)
    state == vrt_pkg::S_WALK_CHK |-> $past(mem_re)) else $error("check without read");

endmodule

// ===== sv/vrt_voxel_mem.sv =====
// Voxel material store: one write port, one registered read port.
// Sweeps all entries to air after reset. Depends on vrt_pkg.
module vrt_voxel_mem #(
  parameter int GRID_SIZE     = vrt_pkg::GRID_SIZE_DEF,
  parameter int MATERIAL_BITS = vrt_pkg::MATERIAL_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        we,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE*GRID_SIZE)-1:0] waddr,
  input  logic [MATERIAL_BITS-1:0]                    wdata,
  input  logic                                        re,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE*GRID_SIZE)-1:0] raddr,
  output logic [MATERIAL_BITS-1:0]                    rdata,
  output logic                                        clearing
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [MATERIAL_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]            clr_addr;

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port, shared with the sweep
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on vrt_pkg for widths and the unit handshake structs.
module vrt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  vrt_pkg::unit_req_t            req,
  input  logic [vrt_pkg::NUM_W-1:0]     num,
  input  logic [vrt_pkg::DEN_W-1:0]     den,
  output vrt_pkg::unit_rsp_t            rsp,
  output logic [vrt_pkg::NUM_W-1:0]     quot
);

  localparam int NW = vrt_pkg::NUM_W;
  localparam int DW = vrt_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]     rem;
  logic [DW:0]     rem_sh;
  logic [DW-1:0]   den_r;
  logic [CW-1:0]   cnt;
  logic            ge;

  assign rem_sh = {rem[DW-1:0], quot[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.running <= 1'b0;
      rsp.done    <= 1'b0;
      cnt         <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        rsp.running <= 1'b1;
        cnt         <= CW'(NW);
      end else if (rsp.running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          rsp.running <= 1'b0;
          rsp.done    <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath; quotient shifts in where the dividend leaves
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (rsp.running) begin
      rem  <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
      quot <= {quot[NW-2:0], ge};
    end
  end

endmodule

// ===== sv/vrt_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
// Depends on vrt_pkg for widths and the unit handshake structs.
module vrt_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  vrt_pkg::unit_req_t            req,
  input  logic [vrt_pkg::NUM_W-1:0]     rad,
  output vrt_pkg::unit_rsp_t            rsp,
  output logic [vrt_pkg::ROOT_W-1:0]    root
);

  localparam int NW = vrt_pkg::NUM_W;
  localparam int RW = vrt_pkg::ROOT_W;
  localparam int CW = $clog2(RW + 1);

  logic [NW-1:0] v;
  logic [RW+2:0] rem;
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic [CW-1:0] cnt;
  logic          ge;

  // remainder never exceeds twice the root, so the top bits drop safely
  assign rem_sh = {rem[RW:0], v[NW-1:NW-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.running <= 1'b0;
      rsp.done    <= 1'b0;
      cnt         <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        rsp.running <= 1'b1;
        cnt         <= CW'(RW);
      end else if (rsp.running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          rsp.running <= 1'b0;
          rsp.done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (rsp.running) begin
      v    <= {v[NW-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

// ===== tb/vrt_checker.sv =====
// Checker for the voxel ray traversal unit: watches request and result transfers,
// predicts each ray result from its own copy of the voxel volume and compares.
// Depends on vrt_pkg for the axis and request codes.
`timescale 1ns / 100ps

module vrt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               req_type,
  input  logic [4:0]         voxel_x,
  input  logic [4:0]         voxel_y,
  input  logic [4:0]         voxel_z,
  input  logic [7:0]         material_in,
  input  logic signed [23:0] origin_x,
  input  logic signed [23:0] origin_y,
  input  logic signed [23:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [23:0]        max_distance,
  input  logic               done,
  input  logic               hit,
  input  logic [4:0]         hit_x,
  input  logic [4:0]         hit_y,
  input  logic [4:0]         hit_z,
  input  logic [7:0]         hit_material,
  input  logic [23:0]        hit_distance,
  input  logic [1:0]         normal_axis,
  input  logic               normal_negative,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  output int                 errors,
  output logic               pending
);

  localparam int GRID = 32;

  typedef struct {
    logic              hit;
    logic [4:0]        x, y, z;
    logic [7:0]        material;
    logic [23:0]       distance;
    logic [1:0]        axis;
    logic              negative;
    logic signed [23:0] px, py, pz;
  } ray_hit_t;

  logic [7:0] volume [GRID*GRID*GRID];
  ray_hit_t   hits_due [$];

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] clamp24(input longint signed v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // 3D DDA walk over the predicted volume
  function automatic ray_hit_t trace_ray(input logic signed [23:0] o [3],
                                         input logic signed [15:0] d [3],
                                         input logic [23:0] maxd);
    longint signed   org [3];
    longint signed   cpos [3];
    longint unsigned dabs [3], tnext [3], tdelta [3];
    longint unsigned sq, len, travel, limit, mag, d12, off;
    longint signed   num, p;
    bit              pos [3], moving [3];
    bit              stop, in_vol;
    int              a;
    logic [1:0]      axis;
    bit              neg;
    ray_hit_t        r;
    r = '{hit: 0, x: 0, y: 0, z: 0, material: 0, distance: 0, axis: vrt_pkg::AXIS_NONE,
          negative: 0, px: 0, py: 0, pz: 0};
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'(o[i]);
      sq += longint'(d[i]) * longint'(d[i]);
    end
    limit = longint'(maxd) << 12;
    if (sq == 0) return r;
    len = int_sqrt(sq << 28);
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? -longint'(d[i]) : longint'(d[i]);
      cpos[i] = org[i] >>> 12;
      pos[i] = d[i] > 0;
      moving[i] = d[i] != 0;
      dabs[i] = moving[i] ? (mag << 44) / len : 0;
      if (moving[i] && dabs[i] != 0) begin
        num = pos[i] ? (cpos[i] + 1) * 4096 - org[i] : org[i] - cpos[i] * 4096;
        tnext[i] = (longint'(num) << 42) / dabs[i];
        tdelta[i] = (64'd1 << 54) / dabs[i];
      end else begin
        moving[i] = 0;
        tnext[i] = '1;
        tdelta[i] = 0;
      end
    end
    travel = 0;
    axis = vrt_pkg::AXIS_NONE;
    neg = 0;
    stop = 0;
    while (!stop && travel < limit) begin
      in_vol = 1;
      for (int i = 0; i < 3; i++)
        if (cpos[i] < 0 || cpos[i] >= GRID) in_vol = 0;
      if (in_vol) begin
        if (volume[(cpos[0] * GRID + cpos[1]) * GRID + cpos[2]] != 0) begin
          d12 = travel >> 12;
          r.hit = 1;
          r.x = cpos[0][4:0];
          r.y = cpos[1][4:0];
          r.z = cpos[2][4:0];
          r.material = volume[(cpos[0] * GRID + cpos[1]) * GRID + cpos[2]];
          r.distance = d12[23:0];
          r.axis = axis;
          r.negative = neg;
          for (int i = 0; i < 3; i++) begin
            off = (dabs[i] * d12) >> 30;
            p = pos[i] ? org[i] + longint'(off) : org[i] - longint'(off);
            if (i == 0) r.px = clamp24(p);
            else if (i == 1) r.py = clamp24(p);
            else r.pz = clamp24(p);
          end
          return r;
        end
      end else begin
        // outside and moving away (or parallel) on some axis: never comes back
        for (int i = 0; i < 3; i++) begin
          if (cpos[i] < 0 && !(moving[i] && pos[i])) stop = 1;
          if (cpos[i] >= GRID && !(moving[i] && !pos[i])) stop = 1;
        end
      end
      if (!stop) begin
        if (tnext[0] < tnext[1] && tnext[0] < tnext[2]) a = 0;
        else if (tnext[1] < tnext[2]) a = 1;
        else a = 2;
        travel = tnext[a];
        tnext[a] += tdelta[a];
        cpos[a] += pos[a] ? 1 : -1;
        axis = a[1:0];
        neg = pos[a];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // track transfers on both sides
  always @(posedge clk) begin
    logic signed [23:0] o [3];
    logic signed [15:0] d [3];
    ray_hit_t w;
    if (rst) begin
      foreach (volume[i]) volume[i] = 0;
      hits_due.delete();
      errors = 0;
    end else begin
      if (start && !busy) begin
        if (req_type == vrt_pkg::REQ_WRITE) begin
          volume[(int'(voxel_x) * GRID + int'(voxel_y)) * GRID + int'(voxel_z)] = material_in;
        end else begin
          o = '{origin_x, origin_y, origin_z};
          d = '{dir_x, dir_y, dir_z};
          hits_due.insert(hits_due.size(), trace_ray(o, d, max_distance));
        end
      end
      if (done) begin
        if (hits_due.size() == 0) begin
          $error("ray result with no ray outstanding");
          errors++;
        end else begin
          w = hits_due.pop_front();
          check_field("hit", w.hit, hit);
          check_field("hit_x", w.x, hit_x);
          check_field("hit_y", w.y, hit_y);
          check_field("hit_z", w.z, hit_z);
          check_field("hit_material", w.material, hit_material);
          check_field("hit_distance", w.distance, hit_distance);
          check_field("normal_axis", w.axis, normal_axis);
          check_field("normal_negative", w.negative, normal_negative);
          check_field("point_x", w.px, point_x);
          check_field("point_y", w.py, point_y);
          check_field("point_z", w.pz, point_z);
        end
      end
    end
    pending = (hits_due.size() != 0);
  end

endmodule

// ===== tb/tb_voxel_ray_traversal_unit.sv =====
// Testbench top for the voxel ray traversal unit: drives voxel writes and ray casts,
// directed then random, and gives the verdict. Depends on vrt_pkg and vrt_checker.
`timescale 1ns / 100ps

module tb_voxel_ray_traversal_unit;

  localparam int CELL = 4096;  // one cell in Q12.12

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic               req_type = vrt_pkg::REQ_WRITE;
  logic [4:0]         voxel_x = 0, voxel_y = 0, voxel_z = 0;
  logic [7:0]         material_in = 0;
  logic signed [23:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [15:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic [23:0]        max_distance = 0;
  logic               done, hit, normal_negative;
  logic [4:0]         hit_x, hit_y, hit_z;
  logic [7:0]         hit_material;
  logic [23:0]        hit_distance;
  logic [1:0]         normal_axis;
  logic signed [23:0] point_x, point_y, point_z;
  int                 errors;
  logic               pending;
  bit                 quiet_tail = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  voxel_ray_traversal_unit dut (.*);

  vrt_checker u_checker (.*);

  // one transfer; start stays high unless an idle burst follows
  task automatic transfer();
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 9) < 3) begin
      start <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic write_voxel(input int x, input int y, input int z, input int m);
    req_type <= vrt_pkg::REQ_WRITE;
    voxel_x <= 5'(x);
    voxel_y <= 5'(y);
    voxel_z <= 5'(z);
    material_in <= 8'(m);
    origin_x <= 24'($urandom);
    dir_x <= 16'($urandom);
    transfer();
  endtask

  task automatic cast_ray(input int ox, input int oy, input int oz, input int dx,
                          input int dy, input int dz, input int lim);
    req_type <= vrt_pkg::REQ_RAY;
    origin_x <= 24'(ox);
    origin_y <= 24'(oy);
    origin_z <= 24'(oz);
    dir_x <= 16'(dx);
    dir_y <= 16'(dy);
    dir_z <= 16'(dz);
    max_distance <= 24'(lim);
    voxel_x <= 5'($urandom);
    material_in <= 8'($urandom);
    transfer();
  endtask

  // coordinate near the volume: mostly inside, else anywhere within 8 cells around it
  function automatic int near_coord();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 32 * CELL - 1);
    return $urandom_range(0, 48 * CELL) - 8 * CELL;
  endfunction

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: corners, full materials, axis rays, ties, special cases
    write_voxel(0, 0, 0, 8'hFF);
    write_voxel(31, 31, 31, 8'h01);
    write_voxel(16, 16, 16, 8'hA5);
    write_voxel(16, 16, 20, 8'h5A);
    write_voxel(5, 5, 5, 0);
    cast_ray(16 * CELL + 2048, 16 * CELL + 2048, 16 * CELL + 2048, 16384, 0, 0, 100);
    cast_ray(2 * CELL, 16 * CELL + 100, 16 * CELL + 100, 16384, 0, 0, 24'hFFFFFF);
    cast_ray(30 * CELL, 16 * CELL + 100, 16 * CELL + 100, -16384, 0, 0, 24'hFFFFFF);
    cast_ray(16 * CELL + 9, 2 * CELL, 16 * CELL + 9, 0, 32767, 0, 24'hFFFFFF);
    cast_ray(16 * CELL + 9, 16 * CELL + 9, 31 * CELL, 0, 0, -32768, 24'hFFFFFF);
    cast_ray(10 * CELL, 10 * CELL, 10 * CELL, 16384, 16384, 16384, 24'hFFFFFF);
    cast_ray(30 * CELL, 30 * CELL, 30 * CELL, -16384, -16384, -16384, 24'hFFFFFF);
    cast_ray(-CELL / 2, -CELL / 2, -CELL / 2, -32768, -32768, -32768, 24'hFFFFFF);
    cast_ray(40 * CELL, 40 * CELL, 40 * CELL, 32767, 32767, 32767, 24'hFFFFFF);
    cast_ray(-24'sd8388608, 24'sd8388607, 0, 100, -100, 1, 24'hFFFFFF);
    cast_ray(16 * CELL, 16 * CELL, 16 * CELL, 0, 0, 0, 24'hFFFFFF);
    cast_ray(16 * CELL, 16 * CELL, 16 * CELL, 16384, 0, 0, 0);
    cast_ray(2 * CELL, 16 * CELL + 100, 16 * CELL + 100, 16384, 0, 0, 13 * CELL);
    cast_ray(CELL, CELL, CELL, -1, -1, -1, 24'hFFFFFF);
    cast_ray(14 * CELL, 14 * CELL, 14 * CELL, 1, 1, 1, 24'hFFFFFF);
    write_voxel(16, 16, 16, 0);
    cast_ray(16 * CELL + 2048, 16 * CELL + 2048, 16 * CELL + 2048, 0, 0, 16384, 24'hFFFFFF);

    // random: a dense core of voxels, rays mostly starting in or near the volume
    for (n = 0; n < 1800; n++) begin
      if (n > 1500) quiet_tail = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          write_voxel($urandom_range(9, 22), $urandom_range(9, 22), $urandom_range(9, 22),
                      ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255));
        9, 10:
          write_voxel($urandom, $urandom, $urandom, $urandom);
        11:
          cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        12:
          cast_ray(near_coord(), near_coord(), near_coord(), $urandom, $urandom, $urandom,
                   $urandom);
        default:
          cast_ray(near_coord(), near_coord(), near_coord(),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535),
                   $urandom_range(0, 64 * CELL));
      endcase
    end
    start <= 0;

    // let the last ray finish and its result be checked
    @(posedge clk);
    while (busy || pending) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run guard
  initial begin
    #3s;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/vrt_pkg.sv
sv/vrt_voxel_mem.sv
sv/vrt_div.sv
sv/vrt_sqrt.sv
sv/voxel_ray_traversal_unit.sv
tb/vrt_checker.sv
tb/tb_voxel_ray_traversal_unit.sv
